>>> hdl/lerd_pkg.sv
// lerd_pkg: types and constants shared by the log event run detector modules
// holds format codes, status limits, register indexes and the classified beat struct
// no dependencies
package lerd_pkg;

   localparam logic [2:0] FMT_UNKNOWN = 3'd0;
   localparam logic [2:0] FMT_APACHE  = 3'd1;
   localparam logic [2:0] FMT_JSON    = 3'd2;
   localparam logic [2:0] FMT_NGINX   = 3'd3;
   localparam logic [2:0] FMT_SYSLOG  = 3'd4;

   localparam logic [9:0] STATUS_OK         = 10'd200;
   localparam logic [9:0] CLIENT_ERROR_MIN  = 10'd400;
   localparam logic [9:0] CLIENT_ERROR_MAX  = 10'd499;
   localparam logic [9:0] SERVER_ERROR_MIN  = 10'd500;

   localparam logic [1:0] MODE_AUTH   = 2'd0;
   localparam logic [1:0] MODE_SERVER = 2'd1;
   localparam logic [1:0] MODE_VOLUME = 2'd2;
   localparam logic [1:0] MODE_ALL    = 2'd3;

   localparam logic [1:0] CSR_DETECT_MODE   = 2'd0;
   localparam logic [1:0] CSR_AUTH_THRESH   = 2'd1;
   localparam logic [1:0] CSR_SERVER_THRESH = 2'd2;
   localparam logic [1:0] CSR_TRAFFIC_THRESH = 2'd3;

   localparam logic [1:0] RESET_DETECT_MODE    = MODE_ALL;
   localparam logic [7:0] RESET_AUTH_THRESH    = 8'd5;
   localparam logic [7:0] RESET_SERVER_THRESH  = 8'd10;
   localparam logic [7:0] RESET_TRAFFIC_THRESH = 8'd50;

   localparam int RSP_TDATA_W = 152;

   // what one event does to each run and to the totals
   typedef struct packed {
      logic       auth_hit;
      logic       auth_clr;
      logic       se_hit;
      logic       se_clr;
      logic       tr_hit;
      logic       tr_clr;
      logic [1:0] errs;
      logic [1:0] warns;
   } cls_type;

endpackage

>>> hdl/lerd_front.sv
// lerd_front: accepts event beats and classifies them against the detect mode
// registers one classified beat for the queue; uses lerd_pkg
module lerd_front
   import lerd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic [1:0]  detect_mode,
   output logic        cls_valid,
   output cls_type     cls_data,
   input  logic        cls_ready
);

   logic    valid_ff, valid_in;
   cls_type cls_ff, cls_in;
   cls_type cls_new;

   logic [2:0] fmt;
   logic [9:0] status;
   logic       warn, authf, sudo, fw;
   logic       sec_on, perf_on, traf_on;
   logic       auth_ev, se_ev, tr_ev, client_ev;

   assign fmt    = req_tuser;
   assign status = req_tdata[9:0];
   assign warn   = req_tdata[10];
   assign authf  = req_tdata[11];
   assign sudo   = req_tdata[12];
   assign fw     = req_tdata[13];

   always_comb begin
      sec_on    = (detect_mode == MODE_AUTH) || (detect_mode == MODE_ALL);
      perf_on   = (detect_mode == MODE_SERVER) || (detect_mode == MODE_ALL);
      traf_on   = (detect_mode == MODE_VOLUME) || (detect_mode == MODE_ALL);
      auth_ev   = (fmt == FMT_SYSLOG) && authf;
      se_ev     = status >= SERVER_ERROR_MIN;
      tr_ev     = (fmt == FMT_APACHE) && (status == STATUS_OK);
      client_ev = status inside {[CLIENT_ERROR_MIN:CLIENT_ERROR_MAX]};

      cls_new.auth_hit = sec_on && auth_ev;
      cls_new.auth_clr = sec_on && !auth_ev;
      cls_new.se_hit   = perf_on && se_ev;
      cls_new.se_clr   = perf_on && !se_ev && (status != 10'd0);
      cls_new.tr_hit   = traf_on && tr_ev;
      cls_new.tr_clr   = traf_on && !tr_ev;
      cls_new.errs     = {1'b0, cls_new.auth_hit} + {1'b0, cls_new.se_hit};
      cls_new.warns    = {1'b0, client_ev}
                       + {1'b0, ((fmt == FMT_JSON) || (fmt == FMT_NGINX)) && warn}
                       + {1'b0, (fmt == FMT_SYSLOG) && (sudo || fw)};
   end

   assign req_tready = !valid_ff || cls_ready;

   always_comb begin
      valid_in = valid_ff;
      cls_in   = cls_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         cls_in = cls_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cls_ff <= cls_in;
   end

   assign cls_valid = valid_ff;
   assign cls_data  = cls_ff;

endmodule

>>> hdl/lerd_queue.sv
// lerd_queue: short first-in first-out queue of classified beats
// decouples the front from the back; uses lerd_pkg
module lerd_queue
   import lerd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cls_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cls_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cls_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/lerd_back.sv
// lerd_back: updates run counters and saturating totals from classified beats
// holds the result register of the rsp channel; uses lerd_pkg
module lerd_back
   import lerd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cls_valid,
   output logic                   cls_ready,
   input  cls_type                cls_data,
   input  logic [7:0]             auth_thresh,
   input  logic [7:0]             server_thresh,
   input  logic [7:0]             traffic_thresh,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [7:0]  auth_ff, auth_in;
   logic [7:0]  se_run_ff, se_run_in;
   logic [7:0]  tr_run_ff, tr_run_in;
   logic [31:0] lines_ff, lines_in;
   logic [31:0] errors_ff, errors_in;
   logic [31:0] warns_ff, warns_in;
   logic [15:0] brute_ff, brute_in;
   logic [15:0] burst_ff, burst_in;
   logic [15:0] traffic_ff, traffic_in;
   logic        valid_ff, valid_in;
   logic [RSP_TDATA_W-1:0] data_ff, data_in;

   logic [7:0]  auth_inc, se_inc, tr_inc;
   logic        bf_alarm, se_alarm, tr_alarm;
   logic [32:0] err_sum, warn_sum;
   logic        take;

   assign cls_ready = !valid_ff || rsp_tready;
   assign take      = cls_valid && cls_ready;

   always_comb begin
      auth_inc = auth_ff + 8'd1;
      se_inc   = se_run_ff + 8'd1;
      tr_inc   = tr_run_ff + 8'd1;
      bf_alarm = cls_data.auth_hit && (auth_inc >= auth_thresh);
      se_alarm = cls_data.se_hit && (se_inc >= server_thresh);
      tr_alarm = cls_data.tr_hit && (tr_inc >= traffic_thresh);

      auth_in = auth_ff;
      if (cls_data.auth_hit) begin
         auth_in = bf_alarm ? 8'd0 : auth_inc;
      end else if (cls_data.auth_clr) begin
         auth_in = 8'd0;
      end
      se_run_in = se_run_ff;
      if (cls_data.se_hit) begin
         se_run_in = se_alarm ? 8'd0 : se_inc;
      end else if (cls_data.se_clr) begin
         se_run_in = 8'd0;
      end
      tr_run_in = tr_run_ff;
      if (cls_data.tr_hit) begin
         tr_run_in = tr_alarm ? 8'd0 : tr_inc;
      end else if (cls_data.tr_clr) begin
         tr_run_in = 8'd0;
      end

      lines_in = (lines_ff == '1) ? lines_ff : lines_ff + 32'd1;
      err_sum  = {1'b0, errors_ff} + {31'd0, cls_data.errs};
      warn_sum = {1'b0, warns_ff} + {31'd0, cls_data.warns};
      errors_in = err_sum[32] ? '1 : err_sum[31:0];
      warns_in  = warn_sum[32] ? '1 : warn_sum[31:0];
      brute_in   = (bf_alarm && brute_ff != '1) ? brute_ff + 16'd1 : brute_ff;
      burst_in   = (se_alarm && burst_ff != '1) ? burst_ff + 16'd1 : burst_ff;
      traffic_in = (tr_alarm && traffic_ff != '1) ? traffic_ff + 16'd1 : traffic_ff;

      data_in = {1'b0, traffic_in, burst_in, brute_in, warns_in, errors_in, lines_in,
                 tr_alarm, se_alarm, bf_alarm, cls_data.warns, cls_data.errs};

      valid_in = valid_ff;
      if (cls_ready) begin
         valid_in = cls_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         auth_ff    <= '0;
         se_run_ff  <= '0;
         tr_run_ff  <= '0;
         lines_ff   <= '0;
         errors_ff  <= '0;
         warns_ff   <= '0;
         brute_ff   <= '0;
         burst_ff   <= '0;
         traffic_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            auth_ff    <= auth_in;
            se_run_ff  <= se_run_in;
            tr_run_ff  <= tr_run_in;
            lines_ff   <= lines_in;
            errors_ff  <= errors_in;
            warns_ff   <= warns_in;
            brute_ff   <= brute_in;
            burst_ff   <= burst_in;
            traffic_ff <= traffic_in;
         end
      end
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

>>> hdl/log_event_run_detector_core.sv
// log_event_run_detector_core: top level of the log event run detector
// holds the control registers and joins lerd_front, lerd_queue and lerd_back; uses lerd_pkg
//
//  channel | direction | beat contents
//  --------+-----------+-----------------------------------------------------------
//  req_    | in        | one log event to classify
//  rsp_    | out       | per-event counts, alarms and running totals
//  csr_    | in        | register index and write data, always ready
//
// one event per cycle sustained while rsp_ is ready; an event passes from req to rsp
// through the front register, a queue slot and the result register
// reset is synchronous: runs, totals and queue clear, registers take defaults
// a stalled rsp_ fills the queue of QUEUE_DEPTH beats before req_tready drops
module log_event_run_detector_core
   import lerd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,  // http_status, level_is_warn, auth_failure,
                                              // sudo_attempt, firewall_block, zero pad
   input  logic [2:0]             req_tuser,  // log_format
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // item_errors, item_warnings,
                                              // brute_force_alarm, server_error_alarm,
                                              // traffic_alarm, lines_total, errors_total,
                                              // warnings_total, brute_force_detections,
                                              // server_error_detections,
                                              // traffic_detections, zero pad
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [1:0]             csr_index,
   input  logic [7:0]             csr_data
);

   logic [1:0] mode_ff, mode_in;
   logic [7:0] auth_thr_ff, auth_thr_in;
   logic [7:0] se_thr_ff, se_thr_in;
   logic [7:0] tr_thr_ff, tr_thr_in;

   logic    f_valid, f_ready;
   cls_type f_data;
   logic    q_valid, q_ready;
   cls_type q_data;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in     = mode_ff;
      auth_thr_in = auth_thr_ff;
      se_thr_in   = se_thr_ff;
      tr_thr_in   = tr_thr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DETECT_MODE:    mode_in     = csr_data[1:0];
            CSR_AUTH_THRESH:    auth_thr_in = csr_data;
            CSR_SERVER_THRESH:  se_thr_in   = csr_data;
            CSR_TRAFFIC_THRESH: tr_thr_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= RESET_DETECT_MODE;
         auth_thr_ff <= RESET_AUTH_THRESH;
         se_thr_ff   <= RESET_SERVER_THRESH;
         tr_thr_ff   <= RESET_TRAFFIC_THRESH;
      end else begin
         mode_ff     <= mode_in;
         auth_thr_ff <= auth_thr_in;
         se_thr_ff   <= se_thr_in;
         tr_thr_ff   <= tr_thr_in;
      end
   end

   lerd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .detect_mode (mode_ff),
      .cls_valid   (f_valid),
      .cls_data    (f_data),
      .cls_ready   (f_ready)
   );

   lerd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   lerd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cls_valid      (q_valid),
      .cls_ready      (q_ready),
      .cls_data       (q_data),
      .auth_thresh    (auth_thr_ff),
      .server_thresh  (se_thr_ff),
      .traffic_thresh (tr_thr_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

>>> tb/log_event_run_detector_core_tb.sv
// log_event_run_detector_core_tb: self-checking bench for the log event run detector
// predicts every response beat from the accepted events and register writes, checks each field
// depends on lerd_pkg and log_event_run_detector_core
module log_event_run_detector_core_tb;
   import lerd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [2:0] fmt;
      logic [9:0] status;
      logic       warn;
      logic       authf;
      logic       sudo;
      logic       fw;
   } log_item_type;

   // response beat layout, highest field first
   typedef struct packed {
      logic        pad;
      logic [15:0] traffic_det;
      logic [15:0] burst_det;
      logic [15:0] brute_det;
      logic [31:0] warn_total;
      logic [31:0] err_total;
      logic [31:0] line_total;
      logic        tr_alarm;
      logic        se_alarm;
      logic        bf_alarm;
      logic [1:0]  warns;
      logic [1:0]  errs;
   } report_type;

   typedef enum logic [1:0] {
      STRETCH_AUTH,
      STRETCH_SERVER,
      STRETCH_OK,
      STRETCH_NOISE
   } stretch_kind_type;

   class detection_tracker_type;
      logic [1:0]  mode;
      logic [7:0]  auth_thr;
      logic [7:0]  se_thr;
      logic [7:0]  tr_thr;
      logic [7:0]  auth_run;
      logic [7:0]  se_run;
      logic [7:0]  tr_run;
      logic [31:0] lines;
      logic [31:0] errors;
      logic [31:0] warnings;
      logic [15:0] brutes;
      logic [15:0] bursts;
      logic [15:0] floods;
      report_type  awaited[$];
      int unsigned events;
      int unsigned checked;
      int unsigned writes;
      int unsigned mismatches;
      int unsigned bf_seen;
      int unsigned se_seen;
      int unsigned tr_seen;

      function new();
         mode = RESET_DETECT_MODE;
         auth_thr = RESET_AUTH_THRESH;
         se_thr = RESET_SERVER_THRESH;
         tr_thr = RESET_TRAFFIC_THRESH;
         auth_run = '0;
         se_run = '0;
         tr_run = '0;
         lines = '0;
         errors = '0;
         warnings = '0;
         brutes = '0;
         bursts = '0;
         floods = '0;
         events = 0;
         checked = 0;
         writes = 0;
         mismatches = 0;
         bf_seen = 0;
         se_seen = 0;
         tr_seen = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [7:0] value);
         writes++;
         case (idx)
            CSR_DETECT_MODE: mode = value[1:0];
            CSR_AUTH_THRESH: auth_thr = value;
            CSR_SERVER_THRESH: se_thr = value;
            CSR_TRAFFIC_THRESH: tr_thr = value;
            default: ;
         endcase
      endfunction

      function bit bump(inout logic [7:0] run, input logic [7:0] thr);
         run = run + 8'd1;
         if (run >= thr) begin
            run = '0;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function logic [31:0] sat32(logic [31:0] a, logic [1:0] b);
         logic [32:0] sum;
         sum = {1'b0, a} + {31'd0, b};
         return sum[32] ? '1 : sum[31:0];
      endfunction

      function logic [15:0] sat16(logic [15:0] a);
         return (a == 16'hFFFF) ? a : a + 16'd1;
      endfunction

      function void take_event(log_item_type ev);
         report_type r;
         bit      sec_on;
         bit      perf_on;
         bit      traf_on;
         r = '0;
         sec_on = (mode == MODE_AUTH) || (mode == MODE_ALL);
         perf_on = (mode == MODE_SERVER) || (mode == MODE_ALL);
         traf_on = (mode == MODE_VOLUME) || (mode == MODE_ALL);
         if (sec_on) begin
            if (ev.fmt == FMT_SYSLOG && ev.authf) begin
               r.errs = r.errs + 2'd1;
               r.bf_alarm = bump(auth_run, auth_thr);
               if (r.bf_alarm) brutes = sat16(brutes);
            end else begin
               auth_run = '0;
            end
         end
         if (perf_on) begin
            if (ev.status >= SERVER_ERROR_MIN) begin
               r.errs = r.errs + 2'd1;
               r.se_alarm = bump(se_run, se_thr);
               if (r.se_alarm) bursts = sat16(bursts);
            end else if (ev.status != '0) begin
               se_run = '0;
            end
         end
         if (traf_on) begin
            if (ev.fmt == FMT_APACHE && ev.status == STATUS_OK) begin
               r.tr_alarm = bump(tr_run, tr_thr);
               if (r.tr_alarm) floods = sat16(floods);
            end else begin
               tr_run = '0;
            end
         end
         if (ev.status >= CLIENT_ERROR_MIN && ev.status <= CLIENT_ERROR_MAX)
            r.warns = r.warns + 2'd1;
         if ((ev.fmt == FMT_JSON || ev.fmt == FMT_NGINX) && ev.warn)
            r.warns = r.warns + 2'd1;
         if (ev.fmt == FMT_SYSLOG && (ev.sudo || ev.fw))
            r.warns = r.warns + 2'd1;
         lines = sat32(lines, 2'd1);
         errors = sat32(errors, r.errs);
         warnings = sat32(warnings, r.warns);
         r.line_total = lines;
         r.err_total = errors;
         r.warn_total = warnings;
         r.brute_det = brutes;
         r.burst_det = bursts;
         r.traffic_det = floods;
         bf_seen += r.bf_alarm;
         se_seen += r.se_alarm;
         tr_seen += r.tr_alarm;
         events++;
         awaited.push_back(r);
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on beat %0d, %s: expected %0h, got %0h",
                        checked, name, want, got);
         end
      endfunction

      function void match_report(report_type got);
         report_type want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response beat with nothing outstanding: %h", got);
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare("item_errors", 32'(want.errs), 32'(got.errs));
         compare("item_warnings", 32'(want.warns), 32'(got.warns));
         compare("brute_force_alarm", 32'(want.bf_alarm), 32'(got.bf_alarm));
         compare("server_error_alarm", 32'(want.se_alarm), 32'(got.se_alarm));
         compare("traffic_alarm", 32'(want.tr_alarm), 32'(got.tr_alarm));
         compare("lines_total", want.line_total, got.line_total);
         compare("errors_total", want.err_total, got.err_total);
         compare("warnings_total", want.warn_total, got.warn_total);
         compare("brute_force_detections", 32'(want.brute_det), 32'(got.brute_det));
         compare("server_error_detections", 32'(want.burst_det), 32'(got.burst_det));
         compare("traffic_detections", 32'(want.traffic_det), 32'(got.traffic_det));
         compare("pad", 32'(want.pad), 32'(got.pad));
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [15:0]            req_tdata = '0;
   logic [2:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [1:0]             csr_index = '0;
   logic [7:0]             csr_data = '0;

   detection_tracker_type tracker = new();
   int unsigned      burst_left = 0;
   int unsigned      cycle_count = 0;
   logic [7:0]       stall_count = '0;
   logic [1:0]       stall_style = '0;

   log_event_run_detector_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.set_register(csr_index, csr_data);
         if (req_tvalid && req_tready)
            tracker.take_event({req_tuser, req_tdata[9:0], req_tdata[10], req_tdata[11],
                                req_tdata[12], req_tdata[13]});
         if (rsp_tvalid && rsp_tready) tracker.match_report(report_type'(rsp_tdata));
      end
   end

   // receiver back-pressure, changing character each time stall_count[6:0] returns to zero
   always @(posedge clock) begin
      stall_count <= stall_count + 8'd1;
      if (stall_count[6:0] == 7'd0) stall_style <= 2'($urandom_range(0, 3));
      case (stall_style)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_count[3:2] != 2'b11);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, tracker.awaited.size());
         $display("log_event_run_detector_core regression: fail");
         $finish;
      end
   end

   function automatic log_item_type make_item(logic [2:0] fmt, logic [9:0] status, logic warn,
                                              logic authf, logic sudo, logic fw);
      return {fmt, status, warn, authf, sudo, fw};
   endfunction

   function automatic log_item_type random_item(stretch_kind_type kind);
      log_item_type ev;
      ev.fmt = 3'($urandom_range(0, 7));
      ev.status = 10'($urandom);
      ev.warn = 1'($urandom);
      ev.authf = 1'($urandom);
      ev.sudo = 1'($urandom);
      ev.fw = 1'($urandom);
      case (kind)
         STRETCH_AUTH: begin
            ev.fmt = FMT_SYSLOG;
            ev.authf = 1'b1;
            if ($urandom_range(0, 1) == 0) ev.status = '0;
         end
         STRETCH_SERVER: begin
            ev.status = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(500, 1023));
         end
         STRETCH_OK: begin
            ev.fmt = FMT_APACHE;
            ev.status = STATUS_OK;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: ev.status = '0;
               1: ev.status = 10'($urandom_range(400, 499));
               2: ev.status = STATUS_OK;
               3: ev.status = 10'($urandom_range(500, 1023));
               default: ;
            endcase
            if ($urandom_range(0, 2) == 0) ev.fmt = FMT_SYSLOG;
         end
      endcase
      return ev;
   endfunction

   task automatic send_item(input log_item_type ev);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tuser <= ev.fmt;
      req_tdata <= {2'b00, ev.fw, ev.sudo, ev.authf, ev.warn, ev.status};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic apply_settings(input logic [1:0] mode, input logic [7:0] auth_thr,
                                 input logic [7:0] se_thr, input logic [7:0] tr_thr);
      logic [7:0] values[4];
      values[0] = {6'd0, mode};
      values[1] = auth_thr;
      values[2] = se_thr;
      values[3] = tr_thr;
      wait_idle();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 2'(i);
         csr_data <= values[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed runs with random content, the rest noise
   task automatic random_phase(input int unsigned count);
      stretch_kind_type kind;
      int unsigned   len;
      int unsigned   sent;
      bit            paused;
      sent = 0;
      paused = 1'b0;
      while (sent < count) begin
         kind = stretch_kind_type'($urandom_range(0, 3));
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
         repeat (len) begin
            send_item(random_item(kind));
            sent++;
         end
         if (!paused && sent >= count / 2) begin
            wait_idle();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: every format, flag and status boundary
      send_item(make_item(FMT_UNKNOWN, 10'd0, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(FMT_APACHE, STATUS_OK, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(3'd7, 10'd1023, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(FMT_JSON, 10'd404, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(make_item(FMT_NGINX, 10'd499, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(make_item(FMT_SYSLOG, 10'd0, 1'b0, 1'b0, 1'b1, 1'b0));
      send_item(make_item(FMT_SYSLOG, 10'd0, 1'b0, 1'b0, 1'b0, 1'b1));
      repeat (5) send_item(make_item(FMT_SYSLOG, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_item(make_item(FMT_SYSLOG, 10'd500, 1'b1, 1'b1, 1'b1, 1'b1));
      send_item(make_item(FMT_JSON, 10'd0, 1'b0, 1'b1, 1'b0, 1'b0));
      send_item(make_item(3'd5, 10'd400, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(3'd6, 10'd1, 1'b0, 1'b0, 1'b1, 1'b1));
      send_item(make_item(FMT_APACHE, 10'd201, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(make_item(FMT_UNKNOWN, 10'd199, 1'b1, 1'b0, 1'b0, 1'b0));
      send_item(make_item(FMT_NGINX, 10'd550, 1'b0, 1'b0, 1'b0, 1'b0));
      send_item(make_item(FMT_SYSLOG, 10'd0, 1'b1, 1'b0, 1'b0, 1'b0));

      apply_settings(MODE_ALL, 8'd1, 8'd1, 8'd1);
      random_phase(60);
      apply_settings(MODE_AUTH, 8'd255, 8'd3, 8'd2);
      random_phase(60);
      apply_settings(MODE_SERVER, 8'd3, 8'd4, 8'd255);
      random_phase(60);
      apply_settings(MODE_VOLUME, 8'd2, 8'd255, 8'd6);
      random_phase(60);
      apply_settings(MODE_ALL, 8'd0, 8'd0, 8'd0);
      random_phase(50);

      // longest runs, then thresholds dropped under runs in progress
      apply_settings(MODE_ALL, 8'd255, 8'd255, 8'd255);
      repeat (278)
         send_item(make_item(FMT_SYSLOG, 10'($urandom_range(500, 1023)), 1'($urandom),
                             1'b1, 1'($urandom), 1'($urandom)));
      apply_settings(MODE_ALL, 8'd4, 8'd4, 8'd4);
      send_item(make_item(FMT_SYSLOG, 10'd777, 1'b0, 1'b1, 1'b0, 1'b0));
      random_phase(60);
      apply_settings(MODE_ALL, RESET_AUTH_THRESH, RESET_SERVER_THRESH, RESET_TRAFFIC_THRESH);
      random_phase(50);

      wait_idle();
      $display("%0d events through %0d register writes, %0d beats checked",
               tracker.events, tracker.writes, tracker.checked);
      $display("alarms: brute force %0d, server error %0d, traffic %0d",
               tracker.bf_seen, tracker.se_seen, tracker.tr_seen);
      if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
         $display("log_event_run_detector_core regression: pass");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("log_event_run_detector_core regression: fail");
      end
      $finish;
   end

endmodule
